### rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Shared codes, sizes and controller/datapath interface types for the
// sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int DEFAULT_SLOTS = 32;
    localparam int MAX_OUT       = 32;
    localparam int CNT_W         = $clog2(MAX_OUT + 1);

    localparam logic [31:0] DEADLINE_MAX = 32'hffff_ffff;

    // opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_SET   = 2'd2;
    localparam logic [1:0] OP_FREE  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_FAIL    = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;

    // slot status codes
    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // latch the input transfer
        logic tick_inc;   // advance the tick counter
        logic walk_init;  // cur = head, prev = sentinel, clear walk state
        logic walk_adv;   // prev = cur, cur = link[cur]
        logic tk_emit;    // send the pending expiry
        logic tk_take;    // retire head node into the pending register
        logic al_init;    // start free-slot scan
        logic al_next;    // advance free-slot scan
        logic al_ok;      // grant scanned slot
        logic al_fail;    // report allocation failure
        logic sel_alloc;  // status read at scan index instead of slot
        logic un_fix;     // bypass the unlinked node
        logic st_free;    // mark slot free
        logic set_wr;     // store deadline and payload, mark running
        logic in_link_s;  // link[s] = cur, head = s at front
        logic in_link_p;  // link[prev] = s
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic [1:0] st_sel;     // status of selected slot
        logic       s_valid;    // slot index within the pool
        logic       out_free;   // output register can take a result
        logic       more;       // current node expires this tick, within the per-tick limit
        logic       pend_v;     // an expiry waits to be sent
        logic       cur_is_s;   // walk reached the target slot
        logic       cur_sent;   // walk reached the sentinel
        logic       prev_sent;  // walk still at the front
        logic       ins_here;   // insertion point found
        logic       idx_last;   // scan at the last slot
    } t_sts;

endpackage

### rtl/stq_ctrl.sv
// ----------------------------------------------------------------------------
// stq_ctrl
// Operation sequencer: accepts one request at a time and steps the datapath
// through list walks, scans and result transfers.
// ----------------------------------------------------------------------------
module stq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_opcode,
    output logic          o_in_ready,
    input  stq_pkg::t_sts i_sts,
    output stq_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_T_RD  = 4'd1;
    localparam logic [3:0] S_T_CHK = 4'd2;
    localparam logic [3:0] S_A_SCN = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_U_RD  = 4'd5;
    localparam logic [3:0] S_U_CHK = 4'd6;
    localparam logic [3:0] S_SETWR = 4'd7;
    localparam logic [3:0] S_I_RD  = 4'd8;
    localparam logic [3:0] S_I_CHK = 4'd9;
    localparam logic [3:0] S_I_LNK = 4'd10;

    logic [3:0] r_state, n_state;
    logic [1:0] r_op, n_op;

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= stq_pkg::OP_TICK;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_op       = i_opcode;
                    unique case (i_opcode)
                        stq_pkg::OP_TICK: begin
                            o_cmd.tick_inc  = 1'b1;
                            o_cmd.walk_init = 1'b1;
                            n_state         = S_T_RD;
                        end
                        stq_pkg::OP_ALLOC: begin
                            o_cmd.al_init = 1'b1;
                            n_state       = S_A_SCN;
                        end
                        default: n_state = S_CHK;
                    endcase
                end
            end
            S_T_RD: n_state = S_T_CHK;
            S_T_CHK: begin
                if (!i_sts.pend_v || i_sts.out_free) begin
                    o_cmd.tk_emit = i_sts.pend_v;
                    if (i_sts.more) begin
                        o_cmd.tk_take = 1'b1;
                        n_state       = S_T_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_A_SCN: begin
                o_cmd.sel_alloc = 1'b1;
                if (i_sts.st_sel == stq_pkg::ST_FREE) begin
                    if (i_sts.out_free) begin
                        o_cmd.al_ok = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (i_sts.idx_last) begin
                    if (i_sts.out_free) begin
                        o_cmd.al_fail = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else begin
                    o_cmd.al_next = 1'b1;
                end
            end
            S_CHK: begin
                if (!i_sts.s_valid || i_sts.st_sel == stq_pkg::ST_FREE) begin
                    n_state = S_IDLE;
                end else if (i_sts.st_sel == stq_pkg::ST_RUN) begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = S_U_RD;
                end else if (r_op == stq_pkg::OP_SET) begin
                    n_state = S_SETWR;
                end else begin
                    o_cmd.st_free = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_U_RD: n_state = S_U_CHK;
            S_U_CHK: begin
                if (i_sts.cur_sent || i_sts.cur_is_s) begin
                    o_cmd.un_fix = i_sts.cur_is_s;
                    if (r_op == stq_pkg::OP_SET) begin
                        n_state = S_SETWR;
                    end else begin
                        o_cmd.st_free = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else begin
                    o_cmd.walk_adv = 1'b1;
                    n_state        = S_U_RD;
                end
            end
            S_SETWR: begin
                o_cmd.set_wr    = 1'b1;
                o_cmd.walk_init = 1'b1;
                n_state         = S_I_RD;
            end
            S_I_RD: n_state = S_I_CHK;
            S_I_CHK: begin
                if (i_sts.ins_here) begin
                    o_cmd.in_link_s = 1'b1;
                    n_state         = i_sts.prev_sent ? S_IDLE : S_I_LNK;
                end else begin
                    o_cmd.walk_adv = 1'b1;
                    n_state        = S_I_RD;
                end
            end
            S_I_LNK: begin
                o_cmd.in_link_p = 1'b1;
                n_state         = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### rtl/stq_dpath.sv
// ----------------------------------------------------------------------------
// stq_dpath
// Slot storage, sorted list memories, walk pointers, tick counter and the
// result output register.
// ----------------------------------------------------------------------------
module stq_dpath #(
    parameter int SLOTS = stq_pkg::DEFAULT_SLOTS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  stq_pkg::t_cmd i_cmd,
    output stq_pkg::t_sts o_sts,
    input  logic [4:0]    i_slot,
    input  logic [31:0]   i_delay,
    input  logic [31:0]   i_payload,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [1:0]    o_kind,
    output logic [4:0]    o_slot,
    output logic [31:0]   o_payload,
    output logic          o_last
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW = $clog2(SLOTS + 1);
    localparam logic [LW-1:0] SENT = LW'(SLOTS);

    // list memories
    logic [31:0]   m_dl   [SLOTS];
    logic [31:0]   m_pay  [SLOTS];
    logic [LW-1:0] m_link [SLOTS];
    logic [31:0]   r_rd_dl, r_rd_pay;
    logic [LW-1:0] r_rd_link;

    logic [1:0]    r_st [SLOTS];
    logic [4:0]    r_slot;
    logic [31:0]   r_delay, r_pay_in;
    logic [31:0]   r_tick, r_new_dl;
    logic [LW-1:0] r_head, r_cur, r_prev;
    logic [AW-1:0] r_idx;
    logic [stq_pkg::CNT_W-1:0] r_n;
    logic          r_pend_v;
    logic [AW-1:0] r_pend_slot;
    logic [31:0]   r_pend_pay;

    logic          r_out_v, r_out_last;
    logic [1:0]    r_out_kind;
    logic [4:0]    r_out_slot;
    logic [31:0]   r_out_pay;

    logic [AW-1:0] rd_addr, s_addr, st_addr;
    logic [LW-1:0] s_link;
    logic [32:0]   dl_sum;
    logic [31:0]   dl_sat;
    logic          out_free, more;
    logic          st_we;
    logic [AW-1:0] st_wa;
    logic [1:0]    st_wd;
    logic          lk_we;
    logic [AW-1:0] lk_wa;
    logic [LW-1:0] lk_wd;

    assign rd_addr  = (r_cur == SENT) ? '0 : AW'(r_cur);
    assign s_addr   = AW'(r_slot);
    assign s_link   = LW'(s_addr);
    assign st_addr  = i_cmd.sel_alloc ? r_idx : s_addr;
    assign dl_sum   = {1'b0, r_tick} + {1'b0, r_delay};
    assign dl_sat   = dl_sum[32] ? stq_pkg::DEADLINE_MAX : dl_sum[31:0];
    assign out_free = !r_out_v || i_out_ready;
    assign more     = (r_cur != SENT) && (r_n < stq_pkg::CNT_W'(stq_pkg::MAX_OUT))
                      && (r_rd_dl <= r_tick);

    always_comb begin
        o_sts           = '0;
        o_sts.st_sel    = r_st[st_addr];
        o_sts.s_valid   = (int'(r_slot) < SLOTS);
        o_sts.out_free  = out_free;
        o_sts.more      = more;
        o_sts.pend_v    = r_pend_v;
        o_sts.cur_is_s  = (r_cur == s_link);
        o_sts.cur_sent  = (r_cur == SENT);
        o_sts.prev_sent = (r_prev == SENT);
        o_sts.ins_here  = (r_cur == SENT) || (r_new_dl <= r_rd_dl);
        o_sts.idx_last  = (r_idx == AW'(SLOTS - 1));
    end

    // status write select
    always_comb begin
        st_we = 1'b1;
        st_wa = s_addr;
        st_wd = stq_pkg::ST_RUN;
        priority if (i_cmd.tk_take) begin
            st_wa = rd_addr;
            st_wd = stq_pkg::ST_ALLOC;
        end else if (i_cmd.al_ok) begin
            st_wa = r_idx;
            st_wd = stq_pkg::ST_ALLOC;
        end else if (i_cmd.st_free) begin
            st_wd = stq_pkg::ST_FREE;
        end else if (i_cmd.set_wr) begin
            st_wd = stq_pkg::ST_RUN;
        end else begin
            st_we = 1'b0;
        end
    end

    // link write select
    always_comb begin
        lk_we = 1'b1;
        lk_wa = AW'(r_prev);
        lk_wd = r_rd_link;
        priority if (i_cmd.un_fix) begin
            lk_we = !(r_prev == SENT);
        end else if (i_cmd.in_link_s) begin
            lk_wa = s_addr;
            lk_wd = r_cur;
        end else if (i_cmd.in_link_p) begin
            lk_wd = s_link;
        end else begin
            lk_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_dl   <= m_dl[rd_addr];
        r_rd_pay  <= m_pay[rd_addr];
        r_rd_link <= m_link[rd_addr];
        if (i_cmd.set_wr) begin
            m_dl[s_addr]  <= dl_sat;
            m_pay[s_addr] <= r_pay_in;
        end
        if (lk_we) begin
            m_link[lk_wa] <= lk_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_st[i] <= stq_pkg::ST_FREE;
            end
        end else if (st_we) begin
            r_st[st_wa] <= st_wd;
        end
    end

    // payload, walk pointer, scan index and pending expiry registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_slot   <= i_slot;
            r_delay  <= i_delay;
            r_pay_in <= i_payload;
        end
        if (i_cmd.set_wr) begin
            r_new_dl <= dl_sat;
        end
        if (i_cmd.walk_init) begin
            r_cur  <= r_head;
            r_prev <= SENT;
            r_n    <= '0;
        end else if (i_cmd.walk_adv) begin
            r_prev <= r_cur;
            r_cur  <= r_rd_link;
        end else if (i_cmd.tk_take) begin
            r_cur <= r_rd_link;
            r_n   <= r_n + 1'b1;
        end
        if (i_cmd.al_init) begin
            r_idx <= '0;
        end else if (i_cmd.al_next) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.tk_take) begin
            r_pend_slot <= rd_addr;
            r_pend_pay  <= r_rd_pay;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= SENT;
            r_tick   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.tick_inc && r_tick != stq_pkg::DEADLINE_MAX) begin
                r_tick <= r_tick + 32'd1;
            end
            priority if (i_cmd.tk_take || i_cmd.un_fix) begin
                if (i_cmd.tk_take || r_prev == SENT) begin
                    r_head <= r_rd_link;
                end
            end else if (i_cmd.in_link_s && r_prev == SENT) begin
                r_head <= s_link;
            end
            if (i_cmd.walk_init) begin
                r_pend_v <= 1'b0;
            end else if (i_cmd.tk_take) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.tk_emit) begin
                r_pend_v <= 1'b0;
            end
            if (i_cmd.tk_emit || i_cmd.al_ok || i_cmd.al_fail) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.tk_emit) begin
            r_out_kind <= stq_pkg::KIND_EXPIRED;
            r_out_slot <= 5'(r_pend_slot);
            r_out_pay  <= r_pend_pay;
            r_out_last <= !more;
        end else if (i_cmd.al_ok) begin
            r_out_kind <= stq_pkg::KIND_ALLOC;
            r_out_slot <= 5'(r_idx);
            r_out_pay  <= '0;
            r_out_last <= 1'b1;
        end else if (i_cmd.al_fail) begin
            r_out_kind <= stq_pkg::KIND_FAIL;
            r_out_slot <= '0;
            r_out_pay  <= '0;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_kind      = r_out_kind;
    assign o_slot      = r_out_slot;
    assign o_payload   = r_out_pay;
    assign o_last      = r_out_last;

endmodule

### rtl/sorted_timer_queue_unit.sv
// Tick retires each due slot from the list head; allocate scans for a free slot;
// set/free walk the list to unlink a running node, and set walks it again to insert it.
// Throughput: one request at a time; the list walks through the link memory set
// the rate.
// Reset (synchronous, active low): all slots free, list empty, tick count zero.
// Results leave through an output register, so a new request can enter while one waits.
// ----------------------------------------------------------------------------
// sorted_timer_queue_unit
// Timer pool kept as a deadline-sorted linked list ahead of a fixed sentinel.
// Requests: tick, allocate, set timer, free. Tick sends every due timer in
// deadline order and marks the final one with tlast.
// ----------------------------------------------------------------------------
module sorted_timer_queue_unit #(
    parameter int SLOTS = stq_pkg::DEFAULT_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // slot[4:0], delay[36:5], payload[68:37]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // slot_out[4:0], payload_out[36:5]
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    output logic        m_axis_tlast
);

    stq_pkg::t_cmd cmd;
    stq_pkg::t_sts sts;
    logic [4:0]    out_slot;
    logic [31:0]   out_pay;

    // sequencer: takes a request only while idle
    stq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_opcode   (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // storage, list walk and the result register
    stq_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_slot      (s_axis_tdata[4:0]),
        .i_delay     (s_axis_tdata[36:5]),
        .i_payload   (s_axis_tdata[68:37]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_kind      (m_axis_tuser),
        .o_slot      (out_slot),
        .o_payload   (out_pay),
        .o_last      (m_axis_tlast)
    );

    // pack result fields, pad to whole bytes
    assign m_axis_tdata = {3'b000, out_pay, out_slot};

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted timer queue: a directed table walk, an
// expiry burst, random requests, each result checked against an in-bench model.
// ----------------------------------------------------------------------------
module tb;
    import stq_pkg::*;

    localparam int NSLOT = DEFAULT_SLOTS;
    localparam int SENT  = NSLOT;

    typedef struct {
        logic [1:0]  kind;
        logic [4:0]  slot;
        logic [31:0] payload;
        logic        last;
    } t_timer_res;

    typedef struct {
        logic [1:0]  op;
        logic [4:0]  slot;
        logic [31:0] delay;
        logic [31:0] payload;
        logic        chk;       // typed-in result present
        logic [1:0]  ekind;
        logic [4:0]  eslot;
    } t_req_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // slot[4:0], delay[36:5], payload[68:37]
    logic [1:0]  s_axis_tuser;   // opcode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // slot_out[4:0], payload_out[36:5]
    logic [1:0]  m_axis_tuser;   // kind[1:0]
    logic        m_axis_tlast;

    sorted_timer_queue_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    // shadow of the timer pool
    logic [1:0]  sh_status [NSLOT];
    logic [31:0] sh_deadline [NSLOT+1];
    logic [31:0] sh_payload [NSLOT];
    int          sh_link [NSLOT+1];
    int          sh_head;
    logic [31:0] sh_ticks;

    t_timer_res  pending_results[$];
    int          errors;
    bit          stim_done;
    bit          quiet;        // last part of the run: no idling
    bit          hold_rx;      // long receiver hold-off request
    int          rx_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // drop slot s from the sorted list
    function automatic void list_unlink(int s);
        int prev;
        int cur;
        prev = SENT;
        cur = sh_head;
        for (int g = 0; g <= NSLOT && cur != SENT; g++) begin
            if (cur == s) begin
                if (prev == SENT) sh_head = sh_link[cur];
                else sh_link[prev] = sh_link[cur];
                break;
            end
            prev = cur;
            cur = sh_link[cur];
        end
    endfunction

    // place slot s ahead of the first entry with an equal or later deadline
    function automatic void list_insert(int s);
        int prev;
        int cur;
        prev = SENT;
        cur = sh_head;
        for (int g = 0; g <= NSLOT; g++) begin
            if (cur == SENT || sh_deadline[s] <= sh_deadline[cur]) break;
            prev = cur;
            cur = sh_link[cur];
        end
        sh_link[s] = cur;
        if (prev == SENT) sh_head = s;
        else sh_link[prev] = s;
    endfunction

    function automatic void pool_reset();
        for (int i = 0; i < NSLOT; i++) sh_status[i] = ST_FREE;
        sh_deadline[SENT] = DEADLINE_MAX;
        sh_link[SENT] = SENT;
        sh_head = SENT;
        sh_ticks = '0;
    endfunction

    // apply one request to the shadow pool and queue the results it causes
    function automatic void pool_apply(logic [1:0] op, logic [4:0] s, logic [31:0] dly,
                                       logic [31:0] pay);
        t_timer_res r;
        logic [32:0] sum;
        int n;
        n = 0;
        case (op)
            OP_TICK: begin
                if (sh_ticks != DEADLINE_MAX) sh_ticks++;
                while (sh_head != SENT && n < MAX_OUT && sh_deadline[sh_head] <= sh_ticks) begin
                    r.kind = KIND_EXPIRED;
                    r.slot = sh_head[4:0];
                    r.payload = sh_payload[sh_head];
                    r.last = 1'b0;
                    sh_status[sh_head] = ST_ALLOC;
                    sh_head = sh_link[sh_head];
                    pending_results.push_back(r);
                    n++;
                end
                if (n > 0) pending_results[$].last = 1'b1;
            end
            OP_ALLOC: begin
                r = '{KIND_FAIL, 5'd0, 32'd0, 1'b1};
                for (int i = 0; i < NSLOT; i++) begin
                    if (sh_status[i] == ST_FREE) begin
                        sh_status[i] = ST_ALLOC;
                        r.kind = KIND_ALLOC;
                        r.slot = i[4:0];
                        break;
                    end
                end
                pending_results.push_back(r);
            end
            OP_SET: begin
                if (sh_status[s] != ST_FREE) begin
                    if (sh_status[s] == ST_RUN) list_unlink(s);
                    sum = {1'b0, sh_ticks} + {1'b0, dly};
                    sh_deadline[s] = sum[32] ? DEADLINE_MAX : sum[31:0];
                    sh_payload[s] = pay;
                    sh_status[s] = ST_RUN;
                    list_insert(s);
                end
            end
            default: begin
                if (sh_status[s] == ST_RUN) list_unlink(s);
                sh_status[s] = ST_FREE;
            end
        endcase
    endfunction

    // drive one request; returns after its transfer
    task automatic send_request(logic [1:0] op, logic [4:0] s, logic [31:0] dly,
                                logic [31:0] pay);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b0, pay, dly, s};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pool_apply(op, s, dly, pay);
        @(negedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_timer_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            rx_count++;
            if (pending_results.size() == 0) begin
                $error("unexpected result kind=%0d slot=%0d", m_axis_tuser, m_axis_tdata[4:0]);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[4:0] !== want.slot) begin
                    $error("slot_out: expected %0d, got %0d", want.slot, m_axis_tdata[4:0]);
                    errors++;
                end
                if (m_axis_tdata[36:5] !== want.payload) begin
                    $error("payload_out: expected %h, got %h", want.payload,
                           m_axis_tdata[36:5]);
                    errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // receiver back-pressure: random stall bursts, plus one long hold-off
    initial begin
        int burst;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_rx = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 12);
                m_axis_tready <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // directed table; a row with chk set also carries its typed-in result
    t_req_row dir_rows[] = '{
        '{OP_TICK,  5'd0,  32'd0,          32'd0,          1'b0, KIND_ALLOC, 5'd0},
        '{OP_SET,   5'd0,  32'd5,          32'h1111_1111,  1'b0, KIND_ALLOC, 5'd0},
        '{OP_FREE,  5'd0,  32'd0,          32'd0,          1'b0, KIND_ALLOC, 5'd0},
        '{OP_ALLOC, 5'd0,  32'd0,          32'd0,          1'b1, KIND_ALLOC, 5'd0},
        '{OP_ALLOC, 5'd31, 32'd0,          32'd0,          1'b1, KIND_ALLOC, 5'd1},
        '{OP_ALLOC, 5'd0,  32'd0,          32'd0,          1'b1, KIND_ALLOC, 5'd2},
        '{OP_SET,   5'd0,  32'd0,          32'hffff_ffff,  1'b0, KIND_ALLOC, 5'd0},
        '{OP_SET,   5'd1,  32'd1,          32'h0000_0000,  1'b0, KIND_ALLOC, 5'd0},
        '{OP_SET,   5'd2,  32'hffff_ffff,  32'ha5a5_5a5a,  1'b0, KIND_ALLOC, 5'd0},
        '{OP_TICK,  5'd0,  32'd0,          32'd0,          1'b0, KIND_ALLOC, 5'd0},
        '{OP_SET,   5'd1,  32'd3,          32'h5a5a_a5a5,  1'b0, KIND_ALLOC, 5'd0},
        '{OP_SET,   5'd1,  32'd2,          32'h1234_5678,  1'b0, KIND_ALLOC, 5'd0},
        '{OP_SET,   5'd0,  32'd2,          32'h8765_4321,  1'b0, KIND_ALLOC, 5'd0},
        '{OP_FREE,  5'd0,  32'd0,          32'd0,          1'b0, KIND_ALLOC, 5'd0},
        '{OP_FREE,  5'd0,  32'd0,          32'd0,          1'b0, KIND_ALLOC, 5'd0},
        '{OP_TICK,  5'd0,  32'd0,          32'd0,          1'b0, KIND_ALLOC, 5'd0},
        '{OP_TICK,  5'd0,  32'd0,          32'd0,          1'b0, KIND_ALLOC, 5'd0},
        '{OP_ALLOC, 5'd0,  32'd0,          32'd0,          1'b1, KIND_ALLOC, 5'd0}
    };

    initial begin
        int n_items;
        int op_pick;
        logic [1:0]  op;
        logic [4:0]  s;
        logic [31:0] dly;
        t_timer_res  typed;
        errors = 0;
        rx_count = 0;
        stim_done = 1'b0;
        quiet = 1'b0;
        hold_rx = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_TICK;
        pool_reset();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // walk the directed table; typed-in rows check the model agrees
        foreach (dir_rows[k]) begin
            send_request(dir_rows[k].op, dir_rows[k].slot, dir_rows[k].delay,
                         dir_rows[k].payload);
            if (dir_rows[k].chk) begin
                typed = pending_results[$];
                if (typed.kind !== dir_rows[k].ekind || typed.slot !== dir_rows[k].eslot) begin
                    $error("table row %0d: expected kind %0d slot %0d, model gives %0d %0d",
                           k, dir_rows[k].ekind, dir_rows[k].eslot, typed.kind, typed.slot);
                    errors++;
                end
            end
        end

        // fill the pool to exhaustion; the surplus requests report failure
        for (int i = 0; i < NSLOT + 1; i++) send_request(OP_ALLOC, 5'd0, 32'd0, 32'd0);
        // arm every slot due on the next tick: a full burst of expiries
        for (int i = 0; i < NSLOT; i++)
            send_request(OP_SET, i[4:0], 32'd1, $urandom());
        // hold off the receiver across the burst so the block backs up
        hold_rx = 1'b1;
        send_request(OP_TICK, 5'd0, 32'd0, 32'd0);
        for (int i = 0; i < 6; i++) send_request(OP_ALLOC, 5'd0, 32'd0, 32'd0);

        // random part: mostly alloc/set/tick cycles with short delays
        n_items = 0;
        while (n_items < 90) begin
            if (n_items > 70) quiet = 1'b1;
            op_pick = $urandom_range(0, 9);
            s = $urandom_range(0, 3) == 0 ? 5'($urandom()) : 5'($urandom_range(0, 7));
            case ($urandom_range(0, 9))
                0: dly = $urandom();
                1: dly = 32'hffff_ffff - $urandom_range(0, 3);
                default: dly = $urandom_range(0, 6);
            endcase
            if (op_pick < 3) op = OP_TICK;
            else if (op_pick < 5) op = OP_ALLOC;
            else if (op_pick < 9) op = OP_SET;
            else op = OP_FREE;
            send_request(op, s, dly, $urandom());
            n_items++;
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * NSLOT + 20) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
